/* hw/rtl/nfla_pkg.sv */
// ----------------------------------------------------------------------------
// nfla_pkg
// shared types and constants of the next-fit free-list allocator
// ----------------------------------------------------------------------------
package nfla_pkg;

   // field widths of the stream and config ports
   localparam int ADDR_W      = 48;
   localparam int REQ_W       = 32;
   localparam int BYTES_W     = 21;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 96;
   localparam int CSR_DATA_W  = 48;

   // unit geometry
   localparam int UNIT_BYTES = 16;
   localparam int UNIT_SHIFT = 4;
   localparam int MIN_UNITS  = 2;
   localparam int NEED_W     = REQ_W - UNIT_SHIFT + 1;
   localparam logic [ADDR_W-1:0] POOL_BASE_RST  = '0;
   localparam logic [BYTES_W-1:0] POOL_BYTES_RST = 21'd1048576;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic {
      CSR_POOL_BASE  = 1'b0,
      CSR_POOL_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE = 2'd0,
      ST_NULL = 2'd1,
      ST_FAIL = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_INIT, OP_LATCH, OP_DECODE, OP_RD_ROVER, OP_PREV_EV, OP_RD_CUR,
      OP_CUR_STEP, OP_UNLINK, OP_SHRINK, OP_CARVE, OP_ALLOC_DONE, OP_RD_B, OP_B_EV,
      OP_F_WALK, OP_F_FOUND, OP_RD_NX, OP_F_HI, OP_F_LO, OP_RESP
   } dp_op_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_DECODE, S_A_PREV_RD, S_A_PREV_EV, S_A_CUR_RD, S_A_CUR_EV,
      S_A_CARVE, S_A_DONE, S_F_B_RD, S_F_B_EV, S_F_CUR_RD, S_F_CUR_EV, S_F_NX_RD,
      S_F_NX_EV, S_F_LO, S_RESP
   } state_type;

   typedef struct packed {
      dp_op_type  op;
      status_type status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_null;
      logic pool_ok;
      logic reject;
      logic is_free;
      logic fits;
      logic exact;
      logic at_rover;
      logic found;
   } dp_stat_type;

endpackage

/* hw/rtl/nfla_ram.sv */
// ----------------------------------------------------------------------------
// nfla_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module nfla_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/nfla_datapath.sv */
// ----------------------------------------------------------------------------
// nfla_datapath
// pool registers, header ram, walk pointers and result register
// ----------------------------------------------------------------------------
module nfla_datapath #(
   parameter int POOL_UNITS = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic                              csr_index,
   input  logic [nfla_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [nfla_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tuser,
   input  nfla_pkg::ctrl_cmd_type            cmd,
   output nfla_pkg::dp_stat_type             stat,
   output logic [nfla_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int NODE_W  = $clog2(POOL_UNITS + 1);
   localparam int RADDR_W = $clog2(POOL_UNITS);
   localparam int RAW_W   = nfla_pkg::BYTES_W - nfla_pkg::UNIT_SHIFT;
   localparam int CMP_W   = (NODE_W > RAW_W) ? NODE_W : RAW_W;
   localparam int NCMP_W  = (NODE_W > nfla_pkg::NEED_W) ? NODE_W : nfla_pkg::NEED_W;
   localparam int IDX_W   = nfla_pkg::ADDR_W - nfla_pkg::UNIT_SHIFT;
   localparam int AW      = nfla_pkg::ADDR_W;
   localparam int BW      = nfla_pkg::BYTES_W;
   localparam int SH      = nfla_pkg::UNIT_SHIFT;

   // config and latched item
   logic [AW-1:0]               base_ff, base_in;
   logic [BW-1:0]               bytes_ff, bytes_in;
   logic                        cmd_ff, cmd_in;
   logic [nfla_pkg::REQ_W-1:0]  req_ff, req_in;
   logic [AW-1:0]               addr_ff, addr_in;

   // allocator state and walk registers
   logic              valid_ff, valid_in;
   logic [BW-1:0]     free_ff, free_in;
   logic [NODE_W-1:0] rover_ff, rover_in;
   logic [NODE_W-1:0] anchor_ff, anchor_in;
   logic [NODE_W-1:0] need_ff, need_in;
   logic [NODE_W-1:0] b_ff, b_in;
   logic [NODE_W-1:0] prev_ff, prev_in;
   logic [NODE_W-1:0] prev_size_ff, prev_size_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [NODE_W-1:0] cur_size_ff, cur_size_in;
   logic [NODE_W-1:0] nx_ff, nx_in;
   logic [NODE_W-1:0] bsz_ff, bsz_in;
   logic [NODE_W-1:0] bnew_size_ff, bnew_size_in;
   logic [NODE_W-1:0] bnew_next_ff, bnew_next_in;
   logic [NODE_W-1:0] blk_ff, blk_in;
   logic [AW-1:0]     grant_ff, grant_in;
   logic              rd_zero_ff, rd_zero_in;

   // result register
   logic [nfla_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [AW-1:0]                 out_grant_ff, out_grant_in;
   logic [BW-1:0]                 out_free_ff, out_free_in;
   logic [BW-1:0]                 out_total_ff, out_total_in;

   // ram ports
   logic                  ram_we, ram_re;
   logic [RADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [2*NODE_W-1:0]   ram_wdata, ram_q;
   logic [NODE_W-1:0]     rd_node, wr_node, wr_next, wr_size;
   logic                  wr_en;

   // derived values
   logic [CMP_W-1:0]           units_wide;
   logic [NODE_W-1:0]          units;
   logic                       units_ok;
   logic [BW-1:0]              total_bytes;
   logic [nfla_pkg::REQ_W:0]   req_round;
   logic [nfla_pkg::NEED_W-1:0] need_raw, need_min;
   logic                       too_big;
   logic [AW-1:0]              off;
   logic [IDX_W-1:0]           idx;
   logic                       bad_free;
   logic [NODE_W-1:0]          hnext, hsize;
   logic                       merge_hi, merge_lo;
   logic [NODE_W-1:0]          hi_size, hi_next;

   // pool geometry from the config registers
   assign units_wide  = CMP_W'(bytes_ff[BW-1:SH]);
   assign units       = (units_wide > CMP_W'(POOL_UNITS)) ? NODE_W'(POOL_UNITS)
                                                         : NODE_W'(units_wide);
   assign units_ok    = units >= NODE_W'(nfla_pkg::MIN_UNITS);
   assign total_bytes = BW'({units, {SH{1'b0}}});

   // allocate size in units, header included
   assign req_round = {1'b0, req_ff} + (nfla_pkg::REQ_W + 1)'(nfla_pkg::UNIT_BYTES - 1);
   assign need_raw  = nfla_pkg::NEED_W'(req_round >> SH) + nfla_pkg::NEED_W'(1);
   assign need_min  = (need_raw < nfla_pkg::NEED_W'(nfla_pkg::MIN_UNITS))
                      ? nfla_pkg::NEED_W'(nfla_pkg::MIN_UNITS) : need_raw;
   assign too_big   = NCMP_W'(need_min) > NCMP_W'(units);

   // free address to node id
   assign off      = addr_ff - base_ff;
   assign idx      = off[AW-1:SH];
   assign bad_free = (off[SH-1:0] != '0) || (idx == '0) || (idx > IDX_W'(units));

   // header view, node zero is the anchor
   assign hnext = rd_zero_ff ? anchor_ff : ram_q[2*NODE_W-1:NODE_W];
   assign hsize = rd_zero_ff ? '0 : ram_q[NODE_W-1:0];

   // merge tests of free
   assign merge_hi = ({1'b0, b_ff} + {1'b0, bsz_ff}) == {1'b0, nx_ff};
   assign merge_lo = ({1'b0, cur_ff} + {1'b0, cur_size_ff}) == {1'b0, b_ff};
   assign hi_size  = merge_hi ? (bsz_ff + hsize) : bsz_ff;
   assign hi_next  = merge_hi ? hnext : nx_ff;

   // status to the controller
   always_comb begin
      stat.is_null  = (cmd_ff == nfla_pkg::CMD_FREE) ? (addr_ff == '0) : (req_ff == '0);
      stat.pool_ok  = valid_ff;
      stat.reject   = (cmd_ff == nfla_pkg::CMD_FREE) ? bad_free : too_big;
      stat.is_free  = (cmd_ff == nfla_pkg::CMD_FREE);
      stat.fits     = hsize >= need_ff;
      stat.exact    = hsize == need_ff;
      stat.at_rover = cur_ff == rover_ff;
      stat.found    = ((b_ff > cur_ff) && (b_ff < hnext)) ||
                      ((cur_ff >= hnext) && ((b_ff > cur_ff) || (b_ff < hnext)));
   end

   // read node select
   always_comb begin
      ram_re  = 1'b1;
      rd_node = cur_ff;
      unique case (cmd.op)
         nfla_pkg::OP_RD_ROVER: rd_node = rover_ff;
         nfla_pkg::OP_RD_CUR:   rd_node = cur_ff;
         nfla_pkg::OP_RD_B:     rd_node = b_ff;
         nfla_pkg::OP_RD_NX:    rd_node = nx_ff;
         default:               ram_re  = 1'b0;
      endcase
      ram_raddr  = RADDR_W'(rd_node - NODE_W'(1));
      rd_zero_in = ram_re ? (rd_node == '0) : rd_zero_ff;
   end

   // header write select
   always_comb begin
      wr_en   = 1'b1;
      wr_node = cur_ff;
      wr_next = hnext;
      wr_size = hsize;
      unique case (cmd.op)
         nfla_pkg::OP_INIT: begin
            wr_en   = units_ok;
            wr_node = NODE_W'(1);
            wr_next = '0;
            wr_size = units;
         end
         nfla_pkg::OP_UNLINK: begin
            wr_node = prev_ff;
            wr_size = prev_size_ff;
         end
         nfla_pkg::OP_SHRINK: begin
            wr_size = hsize - need_ff;
         end
         nfla_pkg::OP_CARVE: begin
            wr_node = blk_ff;
            wr_next = '0;
            wr_size = need_ff;
         end
         nfla_pkg::OP_F_HI: begin
            wr_node = b_ff;
            wr_next = hi_next;
            wr_size = hi_size;
         end
         nfla_pkg::OP_F_LO: begin
            wr_next = merge_lo ? bnew_next_ff : b_ff;
            wr_size = merge_lo ? (cur_size_ff + bnew_size_ff) : cur_size_ff;
         end
         default: wr_en = 1'b0;
      endcase
      ram_we    = wr_en && (wr_node != '0);
      ram_waddr = RADDR_W'(wr_node - NODE_W'(1));
      ram_wdata = {wr_next, wr_size};
   end

   // next state of the registers
   always_comb begin
      base_in      = base_ff;
      bytes_in     = bytes_ff;
      cmd_in       = cmd_ff;
      req_in       = req_ff;
      addr_in      = addr_ff;
      valid_in     = valid_ff;
      free_in      = free_ff;
      rover_in     = rover_ff;
      anchor_in    = anchor_ff;
      need_in      = need_ff;
      b_in         = b_ff;
      prev_in      = prev_ff;
      prev_size_in = prev_size_ff;
      cur_in       = cur_ff;
      cur_size_in  = cur_size_ff;
      nx_in        = nx_ff;
      bsz_in       = bsz_ff;
      bnew_size_in = bnew_size_ff;
      bnew_next_in = bnew_next_ff;
      blk_in       = blk_ff;
      grant_in     = grant_ff;
      out_status_in = out_status_ff;
      out_grant_in  = out_grant_ff;
      out_free_in   = out_free_ff;
      out_total_in  = out_total_ff;

      // anchor header writes
      if (wr_en && (wr_node == '0)) begin
         anchor_in = wr_next;
      end

      unique case (cmd.op)
         nfla_pkg::OP_INIT: begin
            rover_in  = '0;
            valid_in  = units_ok;
            free_in   = units_ok ? total_bytes : '0;
            anchor_in = units_ok ? NODE_W'(1) : '0;
         end
         nfla_pkg::OP_LATCH: begin
            cmd_in  = req_tuser;
            req_in  = req_tdata[nfla_pkg::REQ_W-1:0];
            addr_in = req_tdata[nfla_pkg::REQ_W +: AW];
         end
         nfla_pkg::OP_DECODE: begin
            need_in = NODE_W'(need_min);
            b_in    = NODE_W'(idx);
            cur_in  = rover_ff;
         end
         nfla_pkg::OP_PREV_EV: begin
            prev_in      = rover_ff;
            prev_size_in = hsize;
            cur_in       = hnext;
         end
         nfla_pkg::OP_CUR_STEP: begin
            prev_in      = cur_ff;
            prev_size_in = hsize;
            cur_in       = hnext;
         end
         nfla_pkg::OP_UNLINK: begin
            blk_in = cur_ff;
         end
         nfla_pkg::OP_SHRINK: begin
            blk_in = cur_ff + (hsize - need_ff);
         end
         nfla_pkg::OP_ALLOC_DONE: begin
            rover_in = prev_ff;
            free_in  = free_ff - BW'({need_ff, {SH{1'b0}}});
            grant_in = base_ff + AW'({blk_ff, {SH{1'b0}}});
         end
         nfla_pkg::OP_B_EV: begin
            bsz_in  = hsize;
            free_in = free_ff + BW'({hsize, {SH{1'b0}}});
         end
         nfla_pkg::OP_F_WALK: begin
            cur_in = hnext;
         end
         nfla_pkg::OP_F_FOUND: begin
            cur_size_in = hsize;
            nx_in       = hnext;
         end
         nfla_pkg::OP_F_HI: begin
            bnew_size_in = hi_size;
            bnew_next_in = hi_next;
         end
         nfla_pkg::OP_F_LO: begin
            rover_in = cur_ff;
         end
         nfla_pkg::OP_RESP: begin
            out_status_in = cmd.status;
            out_grant_in  = ((cmd.status == nfla_pkg::ST_DONE) &&
                             (cmd_ff == nfla_pkg::CMD_ALLOC)) ? grant_ff : '0;
            out_free_in   = valid_ff ? free_ff : '0;
            out_total_in  = valid_ff ? total_bytes : '0;
         end
         default: begin
         end
      endcase

      // config writes
      if (csr_wen) begin
         unique case (nfla_pkg::csr_index_type'(csr_index))
            nfla_pkg::CSR_POOL_BASE:  base_in  = csr_wdata[AW-1:0];
            nfla_pkg::CSR_POOL_BYTES: bytes_in = csr_wdata[BW-1:0];
            default: begin
            end
         endcase
      end
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= nfla_pkg::POOL_BASE_RST;
         bytes_ff <= nfla_pkg::POOL_BYTES_RST;
      end else begin
         base_ff  <= base_in;
         bytes_ff <= bytes_in;
      end
   end

   // working registers, not reset; the init pass sets up the pool state after reset
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      req_ff        <= req_in;
      addr_ff       <= addr_in;
      valid_ff      <= valid_in;
      free_ff       <= free_in;
      rover_ff      <= rover_in;
      anchor_ff     <= anchor_in;
      need_ff       <= need_in;
      b_ff          <= b_in;
      prev_ff       <= prev_in;
      prev_size_ff  <= prev_size_in;
      cur_ff        <= cur_in;
      cur_size_ff   <= cur_size_in;
      nx_ff         <= nx_in;
      bsz_ff        <= bsz_in;
      bnew_size_ff  <= bnew_size_in;
      bnew_next_ff  <= bnew_next_in;
      blk_ff        <= blk_in;
      grant_ff      <= grant_in;
      rd_zero_ff    <= rd_zero_in;
      out_status_ff <= out_status_in;
      out_grant_ff  <= out_grant_in;
      out_free_ff   <= out_free_in;
      out_total_ff  <= out_total_in;
   end

   // header store: next in the upper half, size in the lower half
   nfla_ram #(
      .WIDTH (2 * NODE_W),
      .DEPTH (POOL_UNITS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign rsp_tdata = {4'b0000, out_total_ff, out_free_ff, out_grant_ff, out_status_ff};

endmodule

/* hw/rtl/nfla_ctrl.sv */
// ----------------------------------------------------------------------------
// nfla_ctrl
// request sequencer and result handshake of the allocator
// ----------------------------------------------------------------------------
module nfla_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_wen,
   input  nfla_pkg::dp_stat_type  stat,
   output nfla_pkg::ctrl_cmd_type cmd
);

   nfla_pkg::state_type  state_ff, state_in;
   nfla_pkg::status_type status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfla_pkg::S_INIT;
         rsp_valid_ff <= 1'b0;
         status_ff    <= nfla_pkg::ST_DONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = nfla_pkg::OP_NONE;
      cmd.status   = status_ff;
      req_tready   = 1'b0;
      unique case (state_ff)
         // set up again while config writes keep coming
         nfla_pkg::S_INIT: begin
            cmd.op = nfla_pkg::OP_INIT;
            if (!csr_wen) begin
               state_in = nfla_pkg::S_IDLE;
            end
         end
         nfla_pkg::S_IDLE: begin
            req_tready = !csr_wen;
            if (csr_wen) begin
               state_in = nfla_pkg::S_INIT;
            end else if (req_tvalid) begin
               cmd.op   = nfla_pkg::OP_LATCH;
               state_in = nfla_pkg::S_DECODE;
            end
         end
         nfla_pkg::S_DECODE: begin
            priority if (stat.is_null) begin
               status_in = nfla_pkg::ST_NULL;
               state_in  = nfla_pkg::S_RESP;
            end else if (!stat.pool_ok || stat.reject) begin
               status_in = nfla_pkg::ST_FAIL;
               state_in  = nfla_pkg::S_RESP;
            end else begin
               cmd.op    = nfla_pkg::OP_DECODE;
               status_in = nfla_pkg::ST_DONE;
               state_in  = stat.is_free ? nfla_pkg::S_F_B_RD : nfla_pkg::S_A_PREV_RD;
            end
         end
         // allocate walk
         nfla_pkg::S_A_PREV_RD: begin
            cmd.op   = nfla_pkg::OP_RD_ROVER;
            state_in = nfla_pkg::S_A_PREV_EV;
         end
         nfla_pkg::S_A_PREV_EV: begin
            cmd.op   = nfla_pkg::OP_PREV_EV;
            state_in = nfla_pkg::S_A_CUR_RD;
         end
         nfla_pkg::S_A_CUR_RD: begin
            cmd.op   = nfla_pkg::OP_RD_CUR;
            state_in = nfla_pkg::S_A_CUR_EV;
         end
         nfla_pkg::S_A_CUR_EV: begin
            priority if (stat.fits && stat.exact) begin
               cmd.op   = nfla_pkg::OP_UNLINK;
               state_in = nfla_pkg::S_A_DONE;
            end else if (stat.fits) begin
               cmd.op   = nfla_pkg::OP_SHRINK;
               state_in = nfla_pkg::S_A_CARVE;
            end else if (stat.at_rover) begin
               status_in = nfla_pkg::ST_FAIL;
               state_in  = nfla_pkg::S_RESP;
            end else begin
               cmd.op   = nfla_pkg::OP_CUR_STEP;
               state_in = nfla_pkg::S_A_CUR_RD;
            end
         end
         nfla_pkg::S_A_CARVE: begin
            cmd.op   = nfla_pkg::OP_CARVE;
            state_in = nfla_pkg::S_A_DONE;
         end
         nfla_pkg::S_A_DONE: begin
            cmd.op   = nfla_pkg::OP_ALLOC_DONE;
            state_in = nfla_pkg::S_RESP;
         end
         // free walk and merge
         nfla_pkg::S_F_B_RD: begin
            cmd.op   = nfla_pkg::OP_RD_B;
            state_in = nfla_pkg::S_F_B_EV;
         end
         nfla_pkg::S_F_B_EV: begin
            cmd.op   = nfla_pkg::OP_B_EV;
            state_in = nfla_pkg::S_F_CUR_RD;
         end
         nfla_pkg::S_F_CUR_RD: begin
            cmd.op   = nfla_pkg::OP_RD_CUR;
            state_in = nfla_pkg::S_F_CUR_EV;
         end
         nfla_pkg::S_F_CUR_EV: begin
            if (stat.found) begin
               cmd.op   = nfla_pkg::OP_F_FOUND;
               state_in = nfla_pkg::S_F_NX_RD;
            end else begin
               cmd.op   = nfla_pkg::OP_F_WALK;
               state_in = nfla_pkg::S_F_CUR_RD;
            end
         end
         nfla_pkg::S_F_NX_RD: begin
            cmd.op   = nfla_pkg::OP_RD_NX;
            state_in = nfla_pkg::S_F_NX_EV;
         end
         nfla_pkg::S_F_NX_EV: begin
            cmd.op   = nfla_pkg::OP_F_HI;
            state_in = nfla_pkg::S_F_LO;
         end
         nfla_pkg::S_F_LO: begin
            cmd.op   = nfla_pkg::OP_F_LO;
            state_in = nfla_pkg::S_RESP;
         end
         // load the result register once it is free
         nfla_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = nfla_pkg::OP_RESP;
               rsp_valid_in = 1'b1;
               state_in     = nfla_pkg::S_IDLE;
            end
         end
         default: state_in = nfla_pkg::S_INIT;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* hw/rtl/next_fit_free_list_allocator_core.sv */
// ----------------------------------------------------------------------------
// next_fit_free_list_allocator_core
// next-fit heap allocator over a pool of 16-byte units
// ----------------------------------------------------------------------------
// Free blocks form a circular, address-ordered list walked from a rover; every
// header visit is one registered read of the single header ram read port. A
// null or rejected item goes straight to the response. An allocate reads the
// rover's header, then examines the free blocks after it until one fits, taking
// an exact fit whole or carving from the tail of a larger block, and fails when
// the walk comes back to the rover. A free reads the freed block's header, walks
// the list from the rover to its insertion point and merges with the upper and
// lower neighbours. A result still waiting in the output register holds the next
// result back until rsp_tready. After reset and after each config write the
// block sets the pool up again as one free block, or marks it unusable when it
// is too small, before it takes an item; back-to-back config writes keep it there.
module next_fit_free_list_allocator_core #(
   parameter int POOL_UNITS = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   // request_bytes, block_address
   input  logic [nfla_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // command
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // status, granted_address, free_bytes, total_bytes
   output logic [nfla_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wen,
   input  logic                              csr_index,
   input  logic [nfla_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   nfla_pkg::ctrl_cmd_type cmd;
   nfla_pkg::dp_stat_type  stat;

   // sequencer
   nfla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath and header store
   nfla_datapath #(
      .POOL_UNITS (POOL_UNITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stream-level test of the next-fit free-list allocator core
// ----------------------------------------------------------------------------
// Allocate and free items go in on the request stream, and each item's single
// response is checked against a local software heap that walks the same
// circular free list. The pool is set up again through the csr port between
// phases, covering unusable, tiny, wrapped-base and full-size pools. The
// request side idles in bursts and the response side stalls on its own
// pattern.
module tb_top;

   localparam int      AW         = nfla_pkg::ADDR_W;
   localparam int      BW         = nfla_pkg::BYTES_W;
   localparam int      CW         = nfla_pkg::CSR_DATA_W;
   localparam int      UNITS_MAX  = 65536;
   localparam longint  WALK_MAX   = 65538;
   localparam longint  MASK48     = 64'hFFFF_FFFF_FFFF;
   localparam longint  MASK21     = 64'h1F_FFFF;
   localparam int      DRAIN_WAIT = 40;
   localparam longint  CYCLE_CAP  = 4000000;

   typedef struct {
      nfla_pkg::status_type status;
      logic [AW-1:0]        granted;
      logic [BW-1:0]        free_b;
      logic [BW-1:0]        total_b;
   } response_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic [nfla_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             req_tuser = 1'b0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [nfla_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b1;
   logic                             csr_wen = 1'b0;
   logic                             csr_index = 1'b0;
   logic [CW-1:0]                    csr_wdata = '0;

   // software copy of the heap
   int unsigned      heap_next [UNITS_MAX];
   int unsigned      heap_size [UNITS_MAX];
   int unsigned      heap_anchor;
   int unsigned      heap_rover;
   longint unsigned  heap_free;
   bit               heap_ok;
   longint unsigned  heap_base;
   longint unsigned  heap_bytes;

   response_type     pending_rsp [$];
   logic [AW-1:0]    live_blocks [$];
   int               errors = 0;
   longint           cycle = 0;
   int               burst_left = 0;

   always #5 clock = ~clock;

   next_fit_free_list_allocator_core uut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // ---------------------------------------------------------------- heap model
   function automatic longint unsigned heap_units();
      longint unsigned u;
      u = heap_bytes / nfla_pkg::UNIT_BYTES;
      return (u > UNITS_MAX) ? UNITS_MAX : u;
   endfunction

   function automatic int unsigned node_next(int unsigned n);
      if (n == 0) return heap_anchor;
      return (n - 1 < UNITS_MAX) ? heap_next[n-1] : 0;
   endfunction

   function automatic longint unsigned node_size(int unsigned n);
      if (n == 0) return 0;
      return (n - 1 < UNITS_MAX) ? heap_size[n-1] : 0;
   endfunction

   function automatic void link_next(int unsigned n, int unsigned v);
      if (n == 0) heap_anchor = v;
      else if (n - 1 < UNITS_MAX) heap_next[n-1] = v;
   endfunction

   function automatic void link_size(int unsigned n, longint unsigned v);
      if (n != 0 && n - 1 < UNITS_MAX) heap_size[n-1] = v[31:0];
   endfunction

   function automatic void heap_init();
      longint unsigned u;
      u = heap_units();
      heap_rover = 0;
      if (u < nfla_pkg::MIN_UNITS) begin
         heap_ok = 0;
         heap_free = 0;
         heap_anchor = 0;
      end else begin
         heap_ok = 1;
         heap_size[0] = u[31:0];
         heap_next[0] = 0;
         heap_anchor = 1;
         heap_free = (u * nfla_pkg::UNIT_BYTES) & MASK21;
      end
   endfunction

   function automatic nfla_pkg::status_type heap_alloc(longint unsigned req,
                                                       output logic [AW-1:0] addr);
      longint unsigned need, sz, i;
      int unsigned prev, cur, blk;
      addr = '0;
      need = (req + nfla_pkg::UNIT_BYTES - 1) / nfla_pkg::UNIT_BYTES + 1;
      if (need < nfla_pkg::MIN_UNITS) need = nfla_pkg::MIN_UNITS;
      if (need > heap_units()) return nfla_pkg::ST_FAIL;
      prev = heap_rover;
      cur = node_next(prev);
      for (i = 0; i < WALK_MAX; i++) begin
         sz = node_size(cur);
         if (sz >= need) begin
            blk = cur;
            // exact fit unlinks, otherwise carve from the tail
            if (sz == need) begin
               link_next(prev, node_next(cur));
            end else begin
               link_size(cur, sz - need);
               blk = cur + int'(sz - need);
               link_size(blk, need);
            end
            heap_rover = prev;
            heap_free = (heap_free - need * nfla_pkg::UNIT_BYTES) & MASK21;
            addr = AW'((heap_base + longint'(blk) * nfla_pkg::UNIT_BYTES) & MASK48);
            return nfla_pkg::ST_DONE;
         end
         if (cur == heap_rover) return nfla_pkg::ST_FAIL;
         prev = cur;
         cur = node_next(cur);
      end
      return nfla_pkg::ST_FAIL;
   endfunction

   function automatic nfla_pkg::status_type heap_release(longint unsigned addr);
      longint unsigned off, idx, bsz, i;
      int unsigned b, cur, nx;
      off = (addr - heap_base) & MASK48;
      if (off % nfla_pkg::UNIT_BYTES != 0) return nfla_pkg::ST_FAIL;
      idx = off / nfla_pkg::UNIT_BYTES;
      if (idx < 1 || idx - 1 >= heap_units()) return nfla_pkg::ST_FAIL;
      b = idx[31:0];
      bsz = node_size(b);
      heap_free = (heap_free + bsz * nfla_pkg::UNIT_BYTES) & MASK21;
      // find the insertion point in address order
      cur = heap_rover;
      for (i = 0; i < WALK_MAX; i++) begin
         nx = node_next(cur);
         if (b > cur && b < nx) break;
         if (cur >= nx && (b > cur || b < nx)) break;
         cur = nx;
      end
      // merge with upper then lower neighbor
      nx = node_next(cur);
      if (longint'(b) + bsz == longint'(nx)) begin
         link_size(b, bsz + node_size(nx));
         link_next(b, node_next(nx));
      end else begin
         link_next(b, nx);
      end
      if (longint'(cur) + node_size(cur) == longint'(b)) begin
         link_size(cur, node_size(cur) + node_size(b));
         link_next(cur, node_next(b));
      end else begin
         link_next(cur, b);
      end
      heap_rover = cur;
      return nfla_pkg::ST_DONE;
   endfunction

   function automatic response_type heap_predict(nfla_pkg::command_type cmd,
                                                 logic [nfla_pkg::REQ_W-1:0] req,
                                                 logic [AW-1:0] addr);
      response_type r;
      logic [AW-1:0] g;
      g = '0;
      if (cmd == nfla_pkg::CMD_ALLOC) begin
         if (req == 0) r.status = nfla_pkg::ST_NULL;
         else if (!heap_ok) r.status = nfla_pkg::ST_FAIL;
         else r.status = heap_alloc(64'(req), g);
      end else begin
         if (addr == 0) r.status = nfla_pkg::ST_NULL;
         else if (!heap_ok) r.status = nfla_pkg::ST_FAIL;
         else r.status = heap_release(64'(addr));
      end
      r.granted = (r.status == nfla_pkg::ST_DONE) ? g : '0;
      r.free_b  = heap_ok ? heap_free[BW-1:0] : '0;
      r.total_b = heap_ok ? BW'((heap_units() * nfla_pkg::UNIT_BYTES) & MASK21) : '0;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic send_item(nfla_pkg::command_type cmd, logic [nfla_pkg::REQ_W-1:0] req,
                            logic [AW-1:0] addr);
      int gap;
      response_type r;
      // bursts separated by random gaps
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {addr, req};
      do @(posedge clock); while (!req_tready);
      r = heap_predict(cmd, req, addr);
      if (cmd == nfla_pkg::CMD_ALLOC && r.status == nfla_pkg::ST_DONE) begin
         live_blocks.push_back(r.granted);
      end
      pending_rsp.push_back(r);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(nfla_pkg::csr_index_type idx, logic [CW-1:0] val);
      drain();
      @(negedge clock);
      csr_wen = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wen = 1'b0;
      if (idx == nfla_pkg::CSR_POOL_BASE) heap_base = 64'(val);
      else heap_bytes = 64'(val) & MASK21;
      heap_init();
      live_blocks.delete();
   endtask

   task automatic free_random_live();
      int k;
      logic [AW-1:0] a;
      k = $urandom_range(0, live_blocks.size() - 1);
      a = live_blocks[k];
      live_blocks.delete(k);
      send_item(nfla_pkg::CMD_FREE, $urandom, a);
   endtask

   function automatic logic [AW-1:0] rand_addr();
      return AW'({$urandom, $urandom});
   endfunction

   // one random item, mostly well-formed alloc/free traffic
   task automatic send_random_item();
      int r;
      longint unsigned u;
      r = $urandom_range(0, 99);
      u = heap_units();
      if (r < 8) begin
         case ($urandom_range(0, 5))
            0: send_item(nfla_pkg::CMD_ALLOC, '0, rand_addr());
            1: send_item(nfla_pkg::CMD_ALLOC, $urandom, rand_addr());
            2: send_item(nfla_pkg::CMD_FREE, $urandom, '0);
            3: send_item(nfla_pkg::CMD_FREE, $urandom,
                         AW'(heap_base + 16 * $urandom_range(1, 64)
                             + $urandom_range(1, 15)));
            4: send_item(nfla_pkg::CMD_FREE, $urandom,
                         AW'(heap_base + 16 * (u + 1 + $urandom_range(0, 100))));
            default: send_item(nfla_pkg::CMD_FREE, $urandom, AW'(heap_base));
         endcase
      end else if (live_blocks.size() > 0 && r < 50) begin
         free_random_live();
      end else if (r < 88) begin
         send_item(nfla_pkg::CMD_ALLOC, $urandom_range(1, 256), rand_addr());
      end else begin
         send_item(nfla_pkg::CMD_ALLOC, $urandom_range(1, 32'(heap_bytes + 16)),
                   rand_addr());
      end
   endtask

   // ---------------------------------------------------------------- response side
   int stall_mode = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_tready = 1'b1;
         1: rsp_tready = 1'($urandom_range(0, 1));
         default: rsp_tready = ($urandom_range(0, 7) == 0);
      endcase
   end

   // check each accepted response against the oldest prediction
   always @(posedge clock) begin
      response_type e;
      logic [BW-1:0] act_free, act_total;
      logic [AW-1:0] act_granted;
      logic [nfla_pkg::STATUS_W-1:0] act_status;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act_status  = rsp_tdata[1:0];
         act_granted = rsp_tdata[49:2];
         act_free    = rsp_tdata[70:50];
         act_total   = rsp_tdata[91:71];
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response tdata=%h", $time, rsp_tdata);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (act_status != e.status) begin
               $display("%0t: status exp=%0d act=%0d", $time, e.status, act_status);
               errors++;
            end
            if (act_granted != e.granted) begin
               $display("%0t: granted exp=%h act=%h", $time, e.granted, act_granted);
               errors++;
            end
            if (act_free != e.free_b) begin
               $display("%0t: free_bytes exp=%0d act=%0d", $time, e.free_b, act_free);
               errors++;
            end
            if (act_total != e.total_b) begin
               $display("%0t: total_bytes exp=%0d act=%0d", $time, e.total_b, act_total);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle++;
      if (cycle > CYCLE_CAP) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_edge_requests();
      send_item(nfla_pkg::CMD_ALLOC, 32'd1, 48'hFFFF_FFFF_FFFF);
      send_item(nfla_pkg::CMD_ALLOC, 32'd16, '0);
      send_item(nfla_pkg::CMD_ALLOC, 32'd17, rand_addr());
      send_item(nfla_pkg::CMD_ALLOC, '0, rand_addr());
      send_item(nfla_pkg::CMD_FREE, 32'hFFFF_FFFF, '0);
      send_item(nfla_pkg::CMD_ALLOC, 32'hFFFF_FFFF, rand_addr());
      send_item(nfla_pkg::CMD_ALLOC, 32'd1048560, rand_addr());
      send_item(nfla_pkg::CMD_FREE, '0, 48'd8);
      send_item(nfla_pkg::CMD_FREE, '0, 48'hFFFF_FFFF_FFF0);
      // free out of order so both merge directions occur
      while (live_blocks.size() > 0) free_random_live();
   endtask

   task automatic test_tiny_pools();
      // exact fit on a four-unit pool, then exhaustion
      csr_write(nfla_pkg::CSR_POOL_BYTES, 48'd64);
      send_item(nfla_pkg::CMD_ALLOC, 32'd48, rand_addr());
      send_item(nfla_pkg::CMD_ALLOC, 32'd1, rand_addr());
      while (live_blocks.size() > 0) free_random_live();
      send_item(nfla_pkg::CMD_ALLOC, 32'd1, rand_addr());
      send_item(nfla_pkg::CMD_ALLOC, 32'd1, rand_addr());
      while (live_blocks.size() > 0) free_random_live();
      // two units exactly
      csr_write(nfla_pkg::CSR_POOL_BYTES, 48'd33);
      send_item(nfla_pkg::CMD_ALLOC, 32'd16, rand_addr());
      free_random_live();
      // unusable pools
      csr_write(nfla_pkg::CSR_POOL_BYTES, 48'd31);
      send_item(nfla_pkg::CMD_ALLOC, 32'd1, rand_addr());
      send_item(nfla_pkg::CMD_FREE, '0, 48'd32);
      send_item(nfla_pkg::CMD_ALLOC, '0, rand_addr());
      csr_write(nfla_pkg::CSR_POOL_BYTES, 48'd0);
      send_item(nfla_pkg::CMD_FREE, '0, 48'd16);
      send_item(nfla_pkg::CMD_FREE, '0, '0);
      // high base, with a pool one byte short of the default size
      csr_write(nfla_pkg::CSR_POOL_BASE, 48'hFFFF_FFFF_F000);
      csr_write(nfla_pkg::CSR_POOL_BYTES, 48'd1048575);
      send_item(nfla_pkg::CMD_ALLOC, 32'd100, rand_addr());
      send_item(nfla_pkg::CMD_ALLOC, 32'd200, rand_addr());
      while (live_blocks.size() > 0) free_random_live();
   endtask

   task automatic test_random_traffic();
      logic [AW-1:0] bases [4];
      logic [BW-1:0] sizes [4];
      int p, n;
      bases[0] = '0;                   sizes[0] = 21'd1048576;
      bases[1] = 48'hFFFF_FFFF_0000;   sizes[1] = 21'd4096;
      bases[2] = rand_addr() & 48'h7FFF_FFFF_FFFF; sizes[2] = 21'd512;
      bases[3] = rand_addr() >> 2;     sizes[3] = BW'($urandom_range(32, 8192));
      for (p = 0; p < 4; p++) begin
         csr_write(nfla_pkg::CSR_POOL_BASE, CW'(bases[p]));
         csr_write(nfla_pkg::CSR_POOL_BYTES, CW'(sizes[p]));
         for (n = 0; n < 170; n++) begin
            send_random_item();
            // hold off once until everything has come back
            if (p == 1 && n == 80) drain();
         end
      end
   endtask

   initial begin
      heap_base = 64'(nfla_pkg::POOL_BASE_RST);
      heap_bytes = 64'(nfla_pkg::POOL_BYTES_RST);
      heap_init();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_edge_requests();
      test_tiny_pools();
      test_random_traffic();
      drain();

      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/nfla_pkg.sv
hw/rtl/nfla_ram.sv
hw/rtl/nfla_datapath.sv
hw/rtl/nfla_ctrl.sv
hw/rtl/next_fit_free_list_allocator_core.sv
tb/tb_top.sv
